// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that a property holds on every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that an antecedent implies a consequent on the next edge
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

// ----- rtl/core/ezyz_pkg.sv -----
// Package: constants, CORDIC table and types for the Euler z-y-z frame block
`timescale 1ns / 1ps
package ezyz_pkg;
  localparam int AngleBitsDef = 16;
  localparam int CoordFracDef = 12;
  localparam int CordicSteps  = 30;
  localparam int StepBits     = 5;
  localparam int CordW        = 34;   // x/y datapath, Q3.30 plus guard
  localparam int ZW           = 32;
  localparam logic signed [CordW-1:0] GainInv = 34'sd652032874;
  localparam int AxisX = 0;
  localparam int AxisY = 1;
  localparam int AxisZ = 2;

  function automatic logic signed [ZW-1:0] turn_atan(input logic [StepBits-1:0] i);
    logic signed [ZW-1:0] r;
    r = '0;
    case (i)
      5'd0:  r = 32'sh20000000; 5'd1:  r = 32'sh12E4051E; 5'd2:  r = 32'sh09FB385B;
      5'd3:  r = 32'sh051111D4; 5'd4:  r = 32'sh028B0D43; 5'd5:  r = 32'sh0145D7E1;
      5'd6:  r = 32'sh00A2F61E; 5'd7:  r = 32'sh00517C55; 5'd8:  r = 32'sh0028BE53;
      5'd9:  r = 32'sh00145F2F; 5'd10: r = 32'sh000A2F98; 5'd11: r = 32'sh000517CC;
      5'd12: r = 32'sh00028BE6; 5'd13: r = 32'sh000145F3; 5'd14: r = 32'sh0000A2FA;
      5'd15: r = 32'sh0000517D; 5'd16: r = 32'sh000028BE; 5'd17: r = 32'sh0000145F;
      5'd18: r = 32'sh00000A30; 5'd19: r = 32'sh00000518; 5'd20: r = 32'sh0000028C;
      5'd21: r = 32'sh00000146; 5'd22: r = 32'sh000000A3; 5'd23: r = 32'sh00000051;
      5'd24: r = 32'sh00000029; 5'd25: r = 32'sh00000014; 5'd26: r = 32'sh0000000A;
      5'd27: r = 32'sh00000005; 5'd28: r = 32'sh00000003; 5'd29: r = 32'sh00000001;
      default: r = '0;
    endcase
    return r;
  endfunction

  // One angle in flight through the CORDIC row
  typedef struct packed {
    logic signed [CordW-1:0] x;
    logic signed [CordW-1:0] y;
    logic signed [ZW-1:0]    z;
    logic [1:0]              quad;
  } rot_t;

  // Item carried alongside the angles: offsets
  typedef struct packed {
    logic signed [15:0] ox;
    logic signed [15:0] oy;
    logic signed [15:0] oz;
  } offs_t;
endpackage

// ----- rtl/core/euler_zyz_axis_frame.sv -----
// Top level: Euler z-y-z frame, three rotated axes plus offset per transfer
//
//   channel | signals                                      | dir
//   in      | in_valid_i/in_ready_o, angle_*_i, offset_*_i  | slave
//   out     | out_valid_o/out_ready_i, axis_index_o, end_*_o, last_axis_o | master
//
// One input transfer yields three output transfers (x, y, z axis), one per
// cycle while out_ready_i is high, so inputs are taken as the buffer empties.
// The pipe is 30 CORDIC cells plus 4 matrix stages plus the output buffer.
// The whole pipe advances as one: it stalls only when the result buffer at
// the end is full and a new result would arrive. Reset clears the valid bits.
`timescale 1ns / 1ps
module euler_zyz_axis_frame import ezyz_pkg::*; #(
  parameter int ANGLE_BITS      = AngleBitsDef,
  parameter int COORD_FRAC_BITS = CoordFracDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [ANGLE_BITS-1:0] angle_first_i,
  input  logic [ANGLE_BITS-1:0] angle_second_i,
  input  logic [ANGLE_BITS-1:0] angle_third_i,
  input  logic signed [15:0]    offset_x_i,
  input  logic signed [15:0]    offset_y_i,
  input  logic signed [15:0]    offset_z_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            axis_index_o,
  output logic signed [15:0]    end_x_o,
  output logic signed [15:0]    end_y_o,
  output logic signed [15:0]    end_z_o,
  output logic                  last_axis_o
);
  `include "assert_macros.svh"

  localparam int Depth = CordicSteps + 4;

  rot_t  chain_a [CordicSteps+1][3];
  offs_t chain_o [CordicSteps+1];
  logic  vld_q [Depth];
  logic  adv;
  logic  signed [15:0] col [3][3];

  // Result buffer: holds one item's three columns, emitted one axis at a time
  logic signed [15:0] buf_q [3][3];
  logic               buf_vld_q;
  logic [1:0]         idx_q;

  // Pipe advances unless the buffer is busy and the last stage holds data
  logic buf_free;
  assign buf_free = !buf_vld_q || (out_ready_i && idx_q == 2'(AxisZ));
  assign adv = buf_free || !vld_q[Depth-1];
  assign in_ready_o = adv;

  // Build the first cell's input: scale angles to a 32-bit turn fraction
  function automatic rot_t seed(input logic [ANGLE_BITS-1:0] a);
    rot_t r;
    logic [31:0] t;
    t = 32'({a, 32'b0} >> ANGLE_BITS);
    r.x = GainInv;
    r.y = '0;
    r.z = ZW'({2'b00, t[29:0]});
    r.quad = t[31:30];
    return r;
  endfunction

  assign chain_a[0][0] = seed(angle_first_i);
  assign chain_a[0][1] = seed(angle_second_i);
  assign chain_a[0][2] = seed(angle_third_i);
  assign chain_o[0] = '{ox: offset_x_i, oy: offset_y_i, oz: offset_z_i};

  for (genvar g = 0; g < CordicSteps; g++) begin : g_cell
    ezyz_cell #(.Step(g)) u_cell (
      .clk_i (clk_i),
      .en_i  (adv),
      .a_i   (chain_a[g]),
      .off_i (chain_o[g]),
      .a_o   (chain_a[g+1]),
      .off_o (chain_o[g+1])
    );
  end

  ezyz_matrix #(.CoordFracBits(COORD_FRAC_BITS)) u_matrix (
    .clk_i (clk_i),
    .en_i  (adv),
    .a_i   (chain_a[CordicSteps]),
    .off_i (chain_o[CordicSteps]),
    .col_o (col)
  );

  // Valid bits ride alongside the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) vld_q[i] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= in_valid_i;
      for (int i = 1; i < Depth; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  // Output buffer: load a finished item, step through its three axes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_vld_q <= 1'b0;
      idx_q     <= 2'(AxisX);
    end else begin
      if (buf_free && vld_q[Depth-1]) begin
        // take the next finished item, start again at the x axis
        buf_vld_q <= 1'b1;
        idx_q     <= 2'(AxisX);
      end else if (buf_vld_q && out_ready_i) begin
        if (idx_q == 2'(AxisZ)) begin
          buf_vld_q <= 1'b0;
          idx_q     <= 2'(AxisX);
        end else begin
          idx_q <= idx_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (buf_free && vld_q[Depth-1]) buf_q <= col;
  end

  assign out_valid_o  = buf_vld_q;
  assign axis_index_o = idx_q;
  assign last_axis_o  = (idx_q == 2'(AxisZ));
  always_comb begin
    end_x_o = buf_q[AxisX][0];
    end_y_o = buf_q[AxisX][1];
    end_z_o = buf_q[AxisX][2];
    case (idx_q)
      2'(AxisY): begin
        end_x_o = buf_q[AxisY][0]; end_y_o = buf_q[AxisY][1]; end_z_o = buf_q[AxisY][2];
      end
      2'(AxisZ): begin
        end_x_o = buf_q[AxisZ][0]; end_y_o = buf_q[AxisZ][1]; end_z_o = buf_q[AxisZ][2];
      end
      default: ;
    endcase
  end

  `ASSERT_CLK(a_idx_range, clk_i, rst_ni, idx_q != 2'd3, "axis index out of range")
  `ASSERT_NEXT(a_stall_holds, clk_i, rst_ni, !adv, vld_q[Depth-1], "pipe stalled while empty")
  `ASSERT_NEXT(a_step_axis, clk_i, rst_ni,
    buf_vld_q && out_ready_i && idx_q == 2'(AxisX), idx_q == 2'(AxisY), "axis order broken")
endmodule

// ----- rtl/core/ezyz_cell.sv -----
// One CORDIC rotation cell: fixed micro-rotation step, three angles in parallel
`timescale 1ns / 1ps
module ezyz_cell import ezyz_pkg::*; #(
  parameter int Step = 0
) (
  input  logic  clk_i,
  input  logic  en_i,
  input  rot_t  a_i [3],
  input  offs_t off_i,
  output rot_t  a_o [3],
  output offs_t off_o
);
  localparam logic [StepBits-1:0] StepIdx = StepBits'(Step);
  rot_t nxt [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      nxt[k] = a_i[k];
      if (!a_i[k].z[ZW-1]) begin
        nxt[k].x = a_i[k].x - (a_i[k].y >>> Step);
        nxt[k].y = a_i[k].y + (a_i[k].x >>> Step);
        nxt[k].z = a_i[k].z - turn_atan(StepIdx);
      end else begin
        nxt[k].x = a_i[k].x + (a_i[k].y >>> Step);
        nxt[k].y = a_i[k].y - (a_i[k].x >>> Step);
        nxt[k].z = a_i[k].z + turn_atan(StepIdx);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_o   <= nxt;
      off_o <= off_i;
    end
  end
endmodule

// ----- rtl/core/ezyz_matrix.sv -----
// Matrix stage: quadrant fix-up, products, rounding, offset add, saturation
`timescale 1ns / 1ps
module ezyz_matrix import ezyz_pkg::*; #(
  parameter int CoordFracBits = CoordFracDef
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  rot_t               a_i [3],
  input  offs_t              off_i,
  output logic signed [15:0] col_o [3][3]
);
  localparam int Sh = 30 - CoordFracBits;
  localparam int MW = CordW;

  function automatic logic signed [MW-1:0] qmul(input logic signed [MW-1:0] p,
                                                input logic signed [MW-1:0] q);
    logic signed [2*MW-1:0] r;
    r = (2*MW)'(p) * (2*MW)'(q) + (2*MW)'(64'sd536870912);
    return MW'(r >>> 30);
  endfunction

  function automatic logic signed [15:0] place(input logic signed [MW-1:0] m,
                                               input logic signed [15:0] off);
    logic signed [MW+1:0] v;
    v = (MW+2)'((m + (MW'(1) <<< (Sh-1))) >>> Sh) + (MW+2)'(off);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  logic signed [MW-1:0] s_q [3], c_q [3];
  offs_t off_q;
  logic signed [MW-1:0] cacb_q, sacb_q, sasc_q, casc_q, sbcc_q, sbsc_q, sacc_q, cacc_q;
  logic signed [MW-1:0] casb_q, sasb_q, cb_q, sc1_q, cc1_q;
  offs_t off1_q;
  logic signed [MW-1:0] m_q [3][3];
  offs_t off2_q;

  // Stage 1: quadrant mapping
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        case (a_i[k].quad)
          2'd0: begin c_q[k] <= a_i[k].x;  s_q[k] <= a_i[k].y;  end
          2'd1: begin c_q[k] <= -a_i[k].y; s_q[k] <= a_i[k].x;  end
          2'd2: begin c_q[k] <= -a_i[k].x; s_q[k] <= -a_i[k].y; end
          default: begin c_q[k] <= a_i[k].y; s_q[k] <= -a_i[k].x; end
        endcase
      end
      off_q <= off_i;
    end
  end

  // Stage 2: pairwise products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cacb_q <= qmul(c_q[0], c_q[1]);
      sacb_q <= qmul(s_q[0], c_q[1]);
      sasc_q <= qmul(s_q[0], s_q[2]);
      casc_q <= qmul(c_q[0], s_q[2]);
      sbcc_q <= qmul(s_q[1], c_q[2]);
      sbsc_q <= qmul(s_q[1], s_q[2]);
      sacc_q <= qmul(s_q[0], c_q[2]);
      cacc_q <= qmul(c_q[0], c_q[2]);
      casb_q <= qmul(c_q[0], s_q[1]);
      sasb_q <= qmul(s_q[0], s_q[1]);
      cb_q   <= c_q[1];
      sc1_q  <= s_q[2];
      cc1_q  <= c_q[2];
      off1_q <= off_q;
    end
  end

  // Stage 3: triple products and sums
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q[0][0] <= qmul(cacb_q, cc1_q) - sasc_q;
      m_q[0][1] <= qmul(sacb_q, cc1_q) + casc_q;
      m_q[0][2] <= -sbcc_q;
      m_q[1][0] <= -sacc_q - qmul(cacb_q, sc1_q);
      m_q[1][1] <= cacc_q - qmul(sacb_q, sc1_q);
      m_q[1][2] <= sbsc_q;
      m_q[2][0] <= casb_q;
      m_q[2][1] <= sasb_q;
      m_q[2][2] <= cb_q;
      off2_q <= off1_q;
    end
  end

  // Stage 4: round, offset, saturate
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        col_o[k][0] <= place(m_q[k][0], off2_q.ox);
        col_o[k][1] <= place(m_q[k][1], off2_q.oy);
        col_o[k][2] <= place(m_q[k][2], off2_q.oz);
      end
    end
  end
endmodule
